// ===== rtl/qoi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared widths, reset values, register map, state and command types of the
// quaternion odometry integrator.
// ----------------------------------------------------------------------------
package qoi_pkg;

    // Default generics of the top level
    localparam int ACC_WIDTH_DEF = 48;
    localparam int QFB_DEF       = 14;

    // Field widths
    localparam int CNT_W    = 16;
    localparam int QUAT_W   = 16;
    localparam int SCALE_W  = 20;
    localparam int THRESH_W = 40;
    localparam int DISP_W   = 48;

    // Distance step and its split for the shared multiplier lanes
    localparam int STEP_W = CNT_W + SCALE_W;
    localparam int LO_W   = STEP_W / 2;
    localparam int HI_W   = STEP_W - LO_W;
    localparam int MA_W   = LO_W + 1;

    // Sum of two squares of quaternion components, with sign
    localparam int SQ_W = 2 * QUAT_W + 1;

    // Register port
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 4;
    localparam int REG_SEL_BIT = 3;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(25561);
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(429496730);

    typedef enum logic {
        REG_SCALE  = 1'b0,
        REG_THRESH = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [THRESH_W-1:0] thresh;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_SUM,
        ST_ACC,
        ST_CMP
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ_WX,
        MUL_SQ_YZ,
        MUL_CROSS,
        MUL_STEP,
        MUL_PROJ_LO,
        MUL_PROJ_HI
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     load_in;
        logic     qa_init;
        logic     qa_sub;
        logic     qb_load;
        logic     step_load;
        logic     pp_init;
        logic     pp_add;
        logic     acc_update;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic emit;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/qoi_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_in_if
// Input channel: encoder count delta and orientation quaternion per beat.
// ----------------------------------------------------------------------------
interface qoi_in_if;
    import qoi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CNT_W-1:0]  wheel_count;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;

    modport source (
        output valid, wheel_count, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );

    modport sink (
        input  valid, wheel_count, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/qoi_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_out_if
// Result channel: accumulated X and Y displacement per beat.
// ----------------------------------------------------------------------------
interface qoi_out_if;
    import qoi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DISP_W-1:0] disp_x;
    logic signed [DISP_W-1:0] disp_y;

    modport source (
        output valid, disp_x, disp_y,
        input  ready
    );

    modport sink (
        input  valid, disp_x, disp_y,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/quaternion_odometry_integrator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_odometry_integrator
// Dead-reckoning integrator: scales encoder counts to distance, projects
// them with the orientation quaternion and emits X/Y when the travelled
// distance reaches the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   i_item   : one beat per encoder/IMU sample (count delta, quaternion Q2.14).
//   o_result : one beat per threshold crossing (disp_x, disp_y, Q.32 metres);
//              most input beats give no result.
//   APB      : distance_scale at 0x0, emit_threshold at 0x8; write while idle.
// Timing:
//   An input beat is taken in the idle state; the item then runs through
//   nine sequencer steps on two shared multiplier lanes (quaternion terms,
//   distance step, two-part projection products, accumulate, compare).
//   A result is registered out of the compare step, and the next input
//   beat is taken only once the item is back in the idle state.
//   The result register lets the next item be taken while a result waits;
//   an item that crosses the threshold while the previous result is still
//   unread holds in the compare step until the sink takes that beat.
// Reset:
//   Synchronous, active low: accumulators clear, registers return to their
//   defaults, no result is pending.
// ----------------------------------------------------------------------------
module quaternion_odometry_integrator #(
    parameter int ACC_WIDTH      = qoi_pkg::ACC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qoi_pkg::QFB_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    qoi_in_if.sink                          i_item,
    qoi_out_if.source                       o_result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [qoi_pkg::APB_AW-1:0] paddr,
    input  wire logic [qoi_pkg::APB_DW-1:0] pwdata,
    output logic      [qoi_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);
    import qoi_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    // Configuration registers
    qoi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    qoi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Arithmetic
    qoi_dp #(
        .ACC_WIDTH      (ACC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_wheel_count (i_item.wheel_count),
        .i_quat_w      (i_item.quat_w),
        .i_quat_x      (i_item.quat_x),
        .i_quat_y      (i_item.quat_y),
        .i_quat_z      (i_item.quat_z),
        .o_stat        (stat),
        .o_disp_x      (o_result.disp_x),
        .o_disp_y      (o_result.disp_y)
    );

    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

    // A result is only loaded when the distance has reached the threshold
    a_load_needs_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.emit)
        else $error("result loaded below threshold");

    // A loaded result shows on the output in the next cycle
    a_load_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_result.valid)
        else $error("loaded result not presented");

    // One item in flight: no input beat right after an accepted one
    a_one_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an item is in flight");

endmodule
`default_nettype wire

// ===== rtl/qoi_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_regs
// APB register file: distance scale at 0x0, emit threshold at 0x8.
// ----------------------------------------------------------------------------
module qoi_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [qoi_pkg::APB_AW-1:0] paddr,
    input  wire logic [qoi_pkg::APB_DW-1:0] pwdata,
    output logic      [qoi_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output qoi_pkg::t_cfg                   o_cfg
);
    import qoi_pkg::*;

    logic [SCALE_W-1:0]  r_scale;
    logic [THRESH_W-1:0] r_thresh;
    t_reg_sel            reg_sel;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_sel'(paddr[REG_SEL_BIT]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Write on the access phase, drop bits above the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_thresh <= THRESH_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SCALE:  r_scale  <= pwdata[SCALE_W-1:0];
                REG_THRESH: r_thresh <= pwdata[THRESH_W-1:0];
                default:    r_scale  <= r_scale;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_sel)
            REG_SCALE:  prdata = APB_DW'(r_scale);
            REG_THRESH: prdata = APB_DW'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.scale  = r_scale;
    assign o_cfg.thresh = r_thresh;

endmodule
`default_nettype wire

// ===== rtl/qoi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_ctrl
// Sequencer of the integrator: steps the datapath through the quaternion
// terms, the distance step, the projections, the accumulate and the
// threshold check, and owns the result valid flag.
// ----------------------------------------------------------------------------
module qoi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire qoi_pkg::t_dp_stat i_stat,
    output qoi_pkg::t_dp_cmd       o_cmd
);
    import qoi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and result flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_M1;
                end
            end
            ST_M1: begin
                o_cmd.mul_sel = MUL_SQ_WX;
                n_state       = ST_M2;
            end
            ST_M2: begin
                o_cmd.mul_sel = MUL_SQ_YZ;
                o_cmd.qa_init = 1'b1;
                n_state       = ST_M3;
            end
            ST_M3: begin
                o_cmd.mul_sel = MUL_CROSS;
                o_cmd.qa_sub  = 1'b1;
                n_state       = ST_M4;
            end
            ST_M4: begin
                o_cmd.mul_sel = MUL_STEP;
                o_cmd.qb_load = 1'b1;
                n_state       = ST_M5;
            end
            ST_M5: begin
                o_cmd.mul_sel   = MUL_PROJ_LO;
                o_cmd.step_load = 1'b1;
                n_state         = ST_M6;
            end
            ST_M6: begin
                o_cmd.mul_sel = MUL_PROJ_HI;
                o_cmd.pp_init = 1'b1;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.pp_add = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_update = 1'b1;
                n_state          = ST_CMP;
            end
            ST_CMP: begin
                // Hold here while a finished result still waits for the sink
                if (!i_stat.emit) begin
                    n_state = ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result flag: set on load, clear when the beat is taken
    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== rtl/qoi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qoi_dp
// Datapath: two registered multiplier lanes, quaternion term accumulators,
// projection partial-product sums, three saturating accumulators, threshold
// compare and the result register.
// ----------------------------------------------------------------------------
module qoi_dp #(
    parameter int ACC_WIDTH      = qoi_pkg::ACC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qoi_pkg::QFB_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire qoi_pkg::t_dp_cmd                  i_cmd,
    input  wire qoi_pkg::t_cfg                     i_cfg,
    input  wire logic signed [qoi_pkg::CNT_W-1:0]  i_wheel_count,
    input  wire logic signed [qoi_pkg::QUAT_W-1:0] i_quat_w,
    input  wire logic signed [qoi_pkg::QUAT_W-1:0] i_quat_x,
    input  wire logic signed [qoi_pkg::QUAT_W-1:0] i_quat_y,
    input  wire logic signed [qoi_pkg::QUAT_W-1:0] i_quat_z,
    output qoi_pkg::t_dp_stat                      o_stat,
    output logic signed [qoi_pkg::DISP_W-1:0]      o_disp_x,
    output logic signed [qoi_pkg::DISP_W-1:0]      o_disp_y
);
    import qoi_pkg::*;

    // Forward and lateral factors after the fraction shift
    localparam int A_W     = SQ_W - QUAT_FRAC_BITS;
    localparam int B_W     = SQ_W + 1 - QUAT_FRAC_BITS;
    localparam int MB_W    = (B_W > SCALE_W + 1) ? B_W : SCALE_W + 1;
    localparam int MP_W    = MA_W + MB_W;
    localparam int PROJ_W  = STEP_W + B_W;
    localparam int PSH_W   = PROJ_W - QUAT_FRAC_BITS;
    localparam int EW      = ((ACC_WIDTH > PSH_W) ? ACC_WIDTH : PSH_W) + 1;
    localparam logic signed [EW-1:0] ACC_MAX_E =
        {{(EW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] ACC_MIN_E =
        {{(EW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

    // Item registers
    logic signed [CNT_W-1:0]      r_cnt;
    logic signed [QUAT_W-1:0]     r_w;
    logic signed [QUAT_W-1:0]     r_x;
    logic signed [QUAT_W-1:0]     r_y;
    logic signed [QUAT_W-1:0]     r_z;

    // Multiplier lanes
    logic signed [MA_W-1:0]       op_a0;
    logic signed [MB_W-1:0]       op_b0;
    logic signed [MA_W-1:0]       op_a1;
    logic signed [MB_W-1:0]       op_b1;
    logic signed [MP_W-1:0]       r_p0;
    logic signed [MP_W-1:0]       r_p1;

    // Intermediate terms
    logic signed [SQ_W-1:0]       r_qa;
    logic signed [SQ_W-1:0]       r_qb;
    logic signed [A_W-1:0]        fwd_k;
    logic signed [B_W-1:0]        lat_k;
    logic signed [STEP_W-1:0]     r_step;
    logic        [LO_W-1:0]       step_lo;
    logic signed [HI_W-1:0]       step_hi;
    logic signed [PROJ_W-1:0]     r_pa;
    logic signed [PROJ_W-1:0]     r_pb;
    logic signed [PSH_W-1:0]      x_del;
    logic signed [PSH_W-1:0]      y_del;

    // Accumulators and result
    logic signed [ACC_WIDTH-1:0]  r_dist;
    logic signed [ACC_WIDTH-1:0]  r_xs;
    logic signed [ACC_WIDTH-1:0]  r_ys;
    logic        [ACC_WIDTH-1:0]  dist_u;
    logic        [ACC_WIDTH-1:0]  dist_mag;
    logic signed [DISP_W-1:0]     r_out_x;
    logic signed [DISP_W-1:0]     r_out_y;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] s,
        input logic signed [EW-1:0]        d
    );
        logic signed [EW-1:0] sum;
        sum = EW'(s) + d;
        if (sum > ACC_MAX_E) begin
            return ACC_MAX_E[ACC_WIDTH-1:0];
        end else if (sum < ACC_MIN_E) begin
            return ACC_MIN_E[ACC_WIDTH-1:0];
        end
        return sum[ACC_WIDTH-1:0];
    endfunction

    // Floor shift of the factors: drop the fraction bits
    assign fwd_k   = r_qa[SQ_W-1:QUAT_FRAC_BITS];
    assign lat_k   = r_qb[SQ_W-1:QUAT_FRAC_BITS-1];
    assign step_lo = r_p0[LO_W-1:0];
    assign step_hi = r_step[STEP_W-1:LO_W];
    assign x_del   = r_pa[PROJ_W-1:QUAT_FRAC_BITS];
    assign y_del   = r_pb[PROJ_W-1:QUAT_FRAC_BITS];

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cnt <= i_wheel_count;
            r_w   <= i_quat_w;
            r_x   <= i_quat_x;
            r_y   <= i_quat_y;
            r_z   <= i_quat_z;
        end
    end

    // Operand select for both lanes
    always_comb begin
        op_a0 = '0;
        op_b0 = '0;
        op_a1 = '0;
        op_b1 = '0;
        case (i_cmd.mul_sel)
            MUL_SQ_WX: begin
                op_a0 = MA_W'(r_w);
                op_b0 = MB_W'(r_w);
                op_a1 = MA_W'(r_x);
                op_b1 = MB_W'(r_x);
            end
            MUL_SQ_YZ: begin
                op_a0 = MA_W'(r_y);
                op_b0 = MB_W'(r_y);
                op_a1 = MA_W'(r_z);
                op_b1 = MB_W'(r_z);
            end
            MUL_CROSS: begin
                op_a0 = MA_W'(r_x);
                op_b0 = MB_W'(r_y);
                op_a1 = MA_W'(r_w);
                op_b1 = MB_W'(r_z);
            end
            MUL_STEP: begin
                op_a0 = MA_W'(r_cnt);
                op_b0 = MB_W'(i_cfg.scale);
            end
            MUL_PROJ_LO: begin
                op_a0 = MA_W'(step_lo);
                op_b0 = MB_W'(fwd_k);
                op_a1 = MA_W'(step_lo);
                op_b1 = MB_W'(lat_k);
            end
            MUL_PROJ_HI: begin
                op_a0 = MA_W'(step_hi);
                op_b0 = MB_W'(fwd_k);
                op_a1 = MA_W'(step_hi);
                op_b1 = MB_W'(lat_k);
            end
            default: begin
                op_a0 = '0;
            end
        endcase
    end

    // Registered products
    always_ff @(posedge i_clk) begin
        r_p0 <= op_a0 * op_b0;
        r_p1 <= op_a1 * op_b1;
    end

    // Quaternion factors, distance step and projection partial sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.qa_init) begin
            r_qa <= r_p0[SQ_W-1:0] + r_p1[SQ_W-1:0];
        end else if (i_cmd.qa_sub) begin
            r_qa <= r_qa - r_p0[SQ_W-1:0] - r_p1[SQ_W-1:0];
        end
        if (i_cmd.qb_load) begin
            r_qb <= r_p0[SQ_W-1:0] + r_p1[SQ_W-1:0];
        end
        if (i_cmd.step_load) begin
            r_step <= r_p0[STEP_W-1:0];
        end
        if (i_cmd.pp_init) begin
            r_pa <= PROJ_W'(r_p0);
            r_pb <= PROJ_W'(r_p1);
        end else if (i_cmd.pp_add) begin
            r_pa <= r_pa + (PROJ_W'(r_p0) <<< LO_W);
            r_pb <= r_pb + (PROJ_W'(r_p1) <<< LO_W);
        end
    end

    // Saturating accumulators, cleared on each emitted result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
        end else if (i_cmd.load_out) begin
            r_dist <= '0;
            r_xs   <= '0;
            r_ys   <= '0;
        end else if (i_cmd.acc_update) begin
            r_dist <= sat_add(r_dist, EW'(r_step));
            r_xs   <= sat_add(r_xs, EW'(x_del));
            r_ys   <= sat_add(r_ys, EW'(y_del));
        end
    end

    // Threshold check on the distance magnitude
    assign dist_u      = r_dist;
    assign dist_mag    = dist_u[ACC_WIDTH-1] ? (~dist_u + ACC_WIDTH'(1)) : dist_u;
    assign o_stat.emit = dist_mag >= ACC_WIDTH'(i_cfg.thresh);

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x <= DISP_W'(r_xs);
            r_out_y <= DISP_W'(r_ys);
        end
    end

    assign o_disp_x = r_out_x;
    assign o_disp_y = r_out_y;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion odometry integrator. Encoder and
// quaternion samples go in through bursts with random gaps, the result
// channel stalls on its own pattern, and every displacement beat is checked
// against an in-bench fixed-point integrator. Register settings change
// between phases over APB and are read back.
// ----------------------------------------------------------------------------
module tb_top;
    import qoi_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 12;
    // An item that gives no result can still be in the sequencer after the last
    // result, so settle a few item times.
    localparam int DRAIN_CYCLES = 30;
    localparam int QFB          = QFB_DEF;
    localparam longint ACC_MAX  = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam int Q_ONE        = 16384;

    typedef struct packed {
        logic signed [CNT_W-1:0]  cnt;
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } odo_sample_t;

    typedef struct packed {
        logic signed [DISP_W-1:0] x;
        logic signed [DISP_W-1:0] y;
    } disp_pair_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    qoi_in_if  sample_if ();
    qoi_out_if disp_if ();

    quaternion_odometry_integrator i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (sample_if),
        .o_result (disp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Integrator copy: registers and the three running sums
    logic [SCALE_W-1:0]  cfg_scale  = SCALE_RST;
    logic [THRESH_W-1:0] cfg_thresh = THRESH_RST;
    longint              dist_acc   = 0;
    longint              xdisp_acc  = 0;
    longint              ydisp_acc  = 0;

    odo_sample_t encoder_samples [$];
    disp_pair_t  owed_disp [$];
    odo_sample_t next_sample;
    disp_pair_t  fresh_disp;
    disp_pair_t  want_disp;
    int          fail_count   = 0;
    bit          sample_taken = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          stall_mode   = 0;
    int          mode_cycles  = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Add with clamping at the signed accumulator limits
    function automatic longint clamp_add(input longint acc, input longint delta);
        if (delta > 0 && acc > ACC_MAX - delta) begin
            return ACC_MAX;
        end
        if (delta < 0 && acc < ACC_MIN - delta) begin
            return ACC_MIN;
        end
        return acc + delta;
    endfunction

    // Advance the odometry sums by one sample; return 1 when X/Y are emitted
    function automatic bit integrate_odometry(input odo_sample_t s, output disp_pair_t d);
        longint cw;
        longint cx;
        longint cy;
        longint cz;
        longint dist_step;
        longint fwd;
        longint lat;
        longint mag;
        cw        = longint'($signed(s.w));
        cx        = longint'($signed(s.x));
        cy        = longint'($signed(s.y));
        cz        = longint'($signed(s.z));
        dist_step = longint'($signed(s.cnt)) * longint'(cfg_scale);
        fwd       = (cw * cw + cx * cx - cy * cy - cz * cz) >>> QFB;
        lat       = (2 * (cx * cy + cw * cz)) >>> QFB;
        dist_acc  = clamp_add(dist_acc, dist_step);
        xdisp_acc = clamp_add(xdisp_acc, (dist_step * fwd) >>> QFB);
        ydisp_acc = clamp_add(ydisp_acc, (dist_step * lat) >>> QFB);
        mag       = (dist_acc < 0) ? -dist_acc : dist_acc;
        d.x       = xdisp_acc[DISP_W-1:0];
        d.y       = ydisp_acc[DISP_W-1:0];
        if (mag >= longint'(cfg_thresh)) begin
            dist_acc  = 0;
            xdisp_acc = 0;
            ydisp_acc = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [QUAT_W-1:0] rand_quat();
        case ($urandom_range(0, 7))
            0: return QUAT_W'(Q_ONE);
            1: return QUAT_W'(-Q_ONE);
            2: return '0;
            3: return QUAT_W'(int'($urandom_range(0, 254)) - 127);
            default: return QUAT_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        endcase
    endfunction

    function automatic logic signed [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 7))
            0: return CNT_W'(32767);
            1: return CNT_W'(-32768);
            2: return '0;
            3: return CNT_W'(int'($urandom_range(0, 128)) - 64);
            default: return CNT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_sample(input int cnt, input int w, input int x, input int y,
                                input int z);
        odo_sample_t s;
        s.cnt = CNT_W'(cnt);
        s.w   = QUAT_W'(w);
        s.x   = QUAT_W'(x);
        s.y   = QUAT_W'(y);
        s.z   = QUAT_W'(z);
        encoder_samples.push_back(s);
    endtask

    task automatic queue_random(input int n);
        odo_sample_t s;
        repeat (n) begin
            s.cnt = rand_count();
            s.w   = rand_quat();
            s.x   = rand_quat();
            s.y   = rand_quat();
            s.z   = rand_quat();
            encoder_samples.push_back(s);
        end
    endtask

    // Alternate the count sign so distance stays near zero while the lateral
    // term keeps the sign of the count: Y climbs into positive clamping.
    // With hold_sign set, keep moving forward until the distance emits.
    task automatic queue_lateral_drift(input int n, input bit hold_sign);
        int s;
        int f1;
        int f2;
        for (int i = 0; i < n; i++) begin
            s  = (hold_sign || (i % 2 == 0)) ? 1 : -1;
            f1 = $urandom_range(0, 1) ? 1 : -1;
            f2 = $urandom_range(0, 1) ? 1 : -1;
            queue_sample(s * int'($urandom_range(32000, 32767)), f2 * Q_ONE, f1 * Q_ONE,
                         f1 * s * Q_ONE, f2 * s * Q_ONE);
        end
    endtask

    // Read a register and compare it with the bench copy
    task automatic check_reg(input t_reg_sel sel);
        logic [APB_DW-1:0] want;
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = APB_AW'(8 * int'(sel));
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got  = prdata;
        want = (sel == REG_SCALE) ? APB_DW'(cfg_scale) : APB_DW'(cfg_thresh);
        if (got !== want) begin
            $display("%0t ns: register %s read expected %0h, got %0h", $time, sel.name(),
                     want, got);
            fail_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write a register, track it in the bench copy, read it back
    task automatic program_reg(input t_reg_sel sel, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(8 * int'(sel));
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == REG_SCALE) begin
            cfg_scale = value[SCALE_W-1:0];
        end else begin
            cfg_thresh = value[THRESH_W-1:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_reg(sel);
    endtask

    // Hold off until every sample is taken and every result has come back
    task automatic wait_drained();
        while (encoder_samples.size() != 0 || sample_if.valid || owed_disp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sample driver: bursts of beats with random gaps, some long gap-free runs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid <= 1'b0;
        end else if (!sample_if.valid || sample_taken) begin
            sample_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                sample_if.valid <= 1'b0;
            end else if (encoder_samples.size() != 0) begin
                next_sample = encoder_samples.pop_front();
                sample_if.wheel_count <= next_sample.cnt;
                sample_if.quat_w      <= next_sample.w;
                sample_if.quat_x      <= next_sample.x;
                sample_if.quat_y      <= next_sample.y;
                sample_if.quat_z      <= next_sample.z;
                sample_if.valid       <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall density changes from stretch to stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            disp_if.ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(50, 400);
            end else begin
                mode_cycles--;
            end
            if (stall_left > 0) begin
                stall_left--;
                disp_if.ready <= 1'b0;
            end else if (stall_mode != 0 &&
                         $urandom_range(0, (stall_mode == 1) ? 7 : 1) == 0) begin
                stall_left = $urandom_range(0, (stall_mode == 1) ? 3 : 11);
                disp_if.ready <= 1'b0;
            end else begin
                disp_if.ready <= 1'b1;
            end
        end
    end

    // Predict on every accepted sample beat
    always @(posedge i_clk) begin
        if (i_rst_n && sample_if.valid && sample_if.ready) begin
            sample_taken = 1'b1;
            if (integrate_odometry(odo_sample_t'({sample_if.wheel_count, sample_if.quat_w,
                                                  sample_if.quat_x, sample_if.quat_y,
                                                  sample_if.quat_z}), fresh_disp)) begin
                owed_disp.push_back(fresh_disp);
            end
        end
    end

    // Check every accepted result beat against the oldest owed displacement
    always @(posedge i_clk) begin
        if (i_rst_n && disp_if.valid && disp_if.ready) begin
            if (owed_disp.size() == 0) begin
                $display("%0t ns: result beat with none expected, disp_x %0d disp_y %0d",
                         $time, disp_if.disp_x, disp_if.disp_y);
                fail_count++;
            end else begin
                want_disp = owed_disp.pop_front();
                if (disp_if.disp_x !== want_disp.x) begin
                    $display("%0t ns: disp_x expected %0d, got %0d", $time, want_disp.x,
                             disp_if.disp_x);
                    fail_count++;
                end
                if (disp_if.disp_y !== want_disp.y) begin
                    $display("%0t ns: disp_y expected %0d, got %0d", $time, want_disp.y,
                             disp_if.disp_y);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and phases
    initial begin
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        sample_if.valid       = 1'b0;
        sample_if.wheel_count = '0;
        sample_if.quat_w      = '0;
        sample_if.quat_x      = '0;
        sample_if.quat_y      = '0;
        sample_if.quat_z      = '0;
        disp_if.ready         = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values, then extremes, rotations, floor rounding, unit-less quats
        check_reg(REG_SCALE);
        check_reg(REG_THRESH);
        queue_sample(0, 0, 0, 0, 0);
        queue_sample(32767, Q_ONE, 0, 0, 0);
        queue_sample(-32768, -Q_ONE, 0, 0, 0);
        queue_sample(32767, 0, 0, 0, Q_ONE);
        queue_sample(32767, 11585, 0, 0, 11585);
        queue_sample(-1, 3, -5, 7, -11);
        queue_sample(1, 1, 0, 0, 0);
        queue_sample(1, 0, 0, 0, 1);
        queue_sample(-7, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_sample(32767, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
        queue_sample(32767, Q_ONE, Q_ONE, 0, 0);
        queue_sample(-32768, 0, Q_ONE, Q_ONE, 0);
        queue_sample(32767, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        queue_random(150);

        // Zero threshold: every beat emits; scale written with excess bits set
        wait_drained();
        program_reg(REG_SCALE, '1);
        program_reg(REG_THRESH, '0);
        queue_sample(0, 0, 0, 0, 0);
        queue_sample(-32768, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_sample(1, 0, 0, 0, Q_ONE);
        queue_sample(32767, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        queue_random(60);

        // Zero scale: distance never moves, nothing emits
        wait_drained();
        program_reg(REG_SCALE, '0);
        program_reg(REG_THRESH, APB_DW'(1));
        queue_random(30);

        // Threshold exactly reached by a positive and by a negative sum
        wait_drained();
        program_reg(REG_SCALE, APB_DW'(1048575));
        program_reg(REG_THRESH, APB_DW'(5 * 1048575));
        queue_sample(4, Q_ONE, 0, 0, 0);
        queue_sample(1, Q_ONE, 0, 0, 0);
        queue_sample(-5, Q_ONE, 0, 0, 0);
        queue_sample(-4, 0, 0, 0, Q_ONE);
        queue_sample(4, 0, 0, 0, Q_ONE);

        // Largest threshold: drive Y into clamping, then move on to emit it
        wait_drained();
        program_reg(REG_THRESH, '1);
        queue_lateral_drift(1100, 1'b0);
        queue_lateral_drift(40, 1'b1);

        // Random settings, threshold between 1 and 40000 counts' worth
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            program_reg(REG_SCALE, APB_DW'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(1, 64) : $urandom_range(1, 1048575)));
            program_reg(REG_THRESH, APB_DW'(64'(cfg_scale) * $urandom_range(1, 40000)));
            queue_random(60);
        end

        // Back to the power-up settings
        wait_drained();
        program_reg(REG_SCALE, APB_DW'(SCALE_RST));
        program_reg(REG_THRESH, APB_DW'(THRESH_RST));
        queue_random(150);

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS quaternion_odometry_integrator");
        end else begin
            $display("FAIL quaternion_odometry_integrator");
        end
        $finish;
    end

    // Run limit
    initial begin
        #6_000_000;
        $display("%0t ns: run limit reached, %0d samples and %0d results outstanding",
                 $time, encoder_samples.size(), owed_disp.size());
        $display("FAIL quaternion_odometry_integrator");
        $finish;
    end

endmodule
